[design/wav_riff_header_parser_macros.svh]
// Assertion macros for the WAV RIFF header parser.
// Both assume a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef WAV_RIFF_HEADER_PARSER_MACROS_SVH
`define WAV_RIFF_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define WRHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define WRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wrhp_pkg.sv]
// Package for the WAV RIFF header parser: constants, phase and command types.
// No dependencies; used by the divider, datapath, controller, top level and testbench.
`timescale 1ns / 1ps

package wrhp_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FRAME_W = 29;

  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] MAGIC_FMT  = 32'h2074_6D66;
  localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

  localparam logic [15:0] TAG_PCM   = 16'h0001;
  localparam logic [15:0] TAG_FLOAT = 16'h0003;
  localparam logic [15:0] TAG_EXT   = 16'hFFFE;

  localparam logic [31:0] FMT_BASE = 32'd16;
  localparam logic [31:0] FMT_MID  = 32'd18;
  localparam logic [31:0] FMT_LONG = 32'd40;

  localparam logic [1:0] KIND_INFO  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_FORMAT    = 3'd2;
  localparam logic [2:0] ERR_FMT_SIZE  = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;
  localparam logic [2:0] ERR_ZERO_FRAME = 3'd5;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_ID1,
    PH_SKSZ1,
    PH_FMTSZ,
    PH_SKIP1,
    PH_FMT,
    PH_EXTRA,
    PH_ID2,
    PH_SKSZ2,
    PH_DATASZ,
    PH_SKIP2,
    PH_DATA,
    PH_IDLE,
    PH_DIV
  } phase_e;

  typedef enum logic [1:0] {
    FSZ_BASE,
    FSZ_MID,
    FSZ_LONG,
    FSZ_BAD
  } fmt_size_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_INFO,
    EMIT_DATA,
    EMIT_ERR
  } emit_e;

  typedef struct packed {
    logic      take_byte;
    logic      load_skip;
    logic      dec_skip;
    logic      load_fmt_size;
    logic      fmt_byte;
    logic      load_extra;
    logic      start_div;
    logic      dec_data;
    emit_e     emit;
    logic      info_from_div;
    logic      last;
    logic [2:0] err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic      word_done;
    logic      word_riff;
    logic      word_wave;
    logic      word_fmt;
    logic      word_data;
    logic      word_zero;
    logic      skip_last;
    logic      fmt_last;
    logic      format_ok;
    fmt_size_e fmt_size;
    logic      frame_zero;
    logic      data_last;
    logic      out_stall;
    logic      div_busy;
    logic      div_done;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sample_byte;
    logic        last;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] frame_count;
    logic [31:0] data_length;
    logic [2:0]  error_code;
  } out_item_t;

endpackage

[design/wrhp_if.sv]
// Stream channel interfaces of the WAV RIFF header parser: byte input and result output.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface wrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       final_byte;

  modport source (output valid, output stream_byte, output final_byte, input ready);
  modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface wrhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  sample_byte;
  logic        last;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [15:0] bits_per_sample;
  logic [31:0] frame_count;
  logic [31:0] data_length;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output sample_byte, output last, output format_code,
    output channel_count, output sample_rate, output bits_per_sample,
    output frame_count, output data_length, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input sample_byte, input last, input format_code,
    input channel_count, input sample_rate, input bits_per_sample,
    input frame_count, input data_length, input error_code, output ready
  );
endinterface

[design/wrhp_div.sv]
// Restoring divider for the frame count: one quotient bit per cycle.
// Depends on wrhp_pkg for the word and frame-size widths.
`timescale 1ns / 1ps

module wrhp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wrhp_pkg::WORD_W-1:0]   dividend_i,
  input  logic [wrhp_pkg::FRAME_W-1:0]  divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [wrhp_pkg::WORD_W-1:0]   quotient_o
);
  import wrhp_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [FRAME_W-1:0] rem_q, rem_d, div_q;
  logic [WORD_W-1:0]  quo_q, quo_d;
  logic [FRAME_W:0]   partial, diff;
  logic               ge;
  logic               last_step;

  assign partial   = {rem_q, quo_q[WORD_W-1]};
  assign diff      = partial - {1'b0, div_q};
  assign ge        = partial >= {1'b0, div_q};
  assign rem_d     = ge ? diff[FRAME_W-1:0] : partial[FRAME_W-1:0];
  assign quo_d     = {quo_q[WORD_W-2:0], ge};
  assign last_step = &cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/wrhp_dp.sv]
// Datapath of the WAV RIFF header parser: word assembly, counters, format fields,
// frame size, divider and the output register. Depends on wrhp_pkg and wrhp_div.
`timescale 1ns / 1ps

module wrhp_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             in_byte_i,
  input  wrhp_pkg::dp_cmd_t      cmd_i,
  input  logic                   out_ready_i,
  output wrhp_pkg::dp_status_t   status_o,
  output logic                   out_valid_o,
  output wrhp_pkg::out_item_t    out_item_o
);
  import wrhp_pkg::*;

  logic [1:0]         idx_q;
  logic [WORD_W-1:0]  asm_q;
  logic [WORD_W-1:0]  word_w;
  logic [WORD_W-1:0]  skip_q;
  logic [WORD_W-1:0]  data_rem_q;
  fmt_size_e          fsz_q, fsz_w;
  logic [15:0]        held_format_q, held_channels_q, held_bits_q;
  logic [31:0]        held_rate_q;
  logic [31:0]        product;
  logic [FRAME_W-1:0] frame_q;
  logic [3:0]         fmt_pos;
  logic [WORD_W-1:0]  extra_len;
  logic               div_busy, div_done;
  logic [WORD_W-1:0]  quotient;
  logic               out_valid_q;
  out_item_t          out_q, out_d;

  assign word_w    = {in_byte_i, asm_q[WORD_W-1:8]};
  assign fmt_pos   = skip_q[3:0];
  assign product   = held_channels_q * held_bits_q;
  assign extra_len = (fsz_q == FSZ_MID) ? (FMT_MID - FMT_BASE) : (FMT_LONG - FMT_BASE);

  always_comb begin
    if (word_w == FMT_BASE) begin
      fsz_w = FSZ_BASE;
    end else if (word_w == FMT_MID) begin
      fsz_w = FSZ_MID;
    end else if (word_w == FMT_LONG) begin
      fsz_w = FSZ_LONG;
    end else begin
      fsz_w = FSZ_BAD;
    end
  end

  wrhp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (word_w),
    .divisor_i  (frame_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.take_byte) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= product[31:3];
    if (cmd_i.take_byte) begin
      asm_q <= word_w;
    end
    if (cmd_i.load_skip) begin
      skip_q <= word_w;
    end else if (cmd_i.dec_skip) begin
      skip_q <= skip_q - 1'b1;
    end else if (cmd_i.load_fmt_size) begin
      skip_q <= '0;
    end else if (cmd_i.load_extra) begin
      skip_q <= extra_len;
    end else if (cmd_i.fmt_byte) begin
      skip_q <= {{(WORD_W-4){1'b0}}, fmt_pos} + 1'b1;
    end
    if (cmd_i.load_fmt_size) begin
      fsz_q <= fsz_w;
    end
    if (cmd_i.fmt_byte) begin
      case (fmt_pos)
        4'd0:    held_format_q[7:0]    <= in_byte_i;
        4'd1:    held_format_q[15:8]   <= in_byte_i;
        4'd2:    held_channels_q[7:0]  <= in_byte_i;
        4'd3:    held_channels_q[15:8] <= in_byte_i;
        4'd4:    held_rate_q[7:0]      <= in_byte_i;
        4'd5:    held_rate_q[15:8]     <= in_byte_i;
        4'd6:    held_rate_q[23:16]    <= in_byte_i;
        4'd7:    held_rate_q[31:24]    <= in_byte_i;
        4'd14:   held_bits_q[7:0]      <= in_byte_i;
        4'd15:   held_bits_q[15:8]     <= in_byte_i;
        default: ;
      endcase
    end
    if (cmd_i.start_div) begin
      data_rem_q <= word_w;
    end else if (cmd_i.dec_data) begin
      data_rem_q <= data_rem_q - 1'b1;
    end
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.emit)
      EMIT_INFO: begin
        out_d.kind            = KIND_INFO;
        out_d.last            = cmd_i.last;
        out_d.format_code     = held_format_q;
        out_d.channel_count   = held_channels_q;
        out_d.sample_rate     = held_rate_q;
        out_d.bits_per_sample = held_bits_q;
        out_d.frame_count     = cmd_i.info_from_div ? quotient : '0;
        out_d.data_length     = cmd_i.info_from_div ? data_rem_q : word_w;
      end
      EMIT_DATA: begin
        out_d.kind        = KIND_DATA;
        out_d.sample_byte = in_byte_i;
        out_d.last        = cmd_i.last;
      end
      EMIT_ERR: begin
        out_d.kind       = KIND_ERROR;
        out_d.error_code = cmd_i.err_code;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EMIT_NONE) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    status_o.word_done  = &idx_q;
    status_o.word_riff  = word_w == MAGIC_RIFF;
    status_o.word_wave  = word_w == MAGIC_WAVE;
    status_o.word_fmt   = word_w == MAGIC_FMT;
    status_o.word_data  = word_w == MAGIC_DATA;
    status_o.word_zero  = word_w == '0;
    status_o.skip_last  = skip_q == {{(WORD_W-1){1'b0}}, 1'b1};
    status_o.fmt_last   = &fmt_pos;
    status_o.format_ok  = (held_format_q == TAG_PCM) || (held_format_q == TAG_FLOAT) ||
                          (held_format_q == TAG_EXT);
    status_o.fmt_size   = fsz_q;
    status_o.frame_zero = frame_q == '0;
    status_o.data_last  = data_rem_q == {{(WORD_W-1){1'b0}}, 1'b1};
    status_o.out_stall  = out_valid_q && !out_ready_i;
    status_o.div_busy   = div_busy;
    status_o.div_done   = div_done;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/wrhp_ctrl.sv]
// Controller of the WAV RIFF header parser: parse-phase state machine that issues
// datapath commands and the input ready. Depends on wrhp_pkg.
`timescale 1ns / 1ps

module wrhp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_final_i,
  output logic                  in_ready_o,
  input  wrhp_pkg::dp_status_t  status_i,
  output wrhp_pkg::dp_cmd_t     cmd_o
);
  import wrhp_pkg::*;

  phase_e     phase_q, phase_d, nom;
  logic       fire;
  logic       err_hit;
  logic [2:0] err_code;

  assign in_ready_o = (phase_q != PH_DIV) && !status_i.out_stall;
  assign fire       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
    end else begin
      phase_q <= phase_d;
    end
  end

  // next state, including errors
  always_comb begin
    nom      = phase_q;
    err_hit  = 1'b0;
    err_code = ERR_NONE;
    if (phase_q == PH_DIV) begin
      if (status_i.div_done) begin
        nom = PH_DATA;
      end
    end else if (fire) begin
      case (phase_q)
        PH_RIFF: begin
          if (status_i.word_done) begin
            if (!status_i.word_riff) begin
              err_hit  = 1'b1;
              err_code = ERR_MAGIC;
            end else begin
              nom = PH_RSIZE;
            end
          end
        end
        PH_RSIZE: begin
          if (status_i.word_done) begin
            nom = PH_WAVE;
          end
        end
        PH_WAVE: begin
          if (status_i.word_done) begin
            if (!status_i.word_wave) begin
              err_hit  = 1'b1;
              err_code = ERR_MAGIC;
            end else begin
              nom = PH_ID1;
            end
          end
        end
        PH_ID1: begin
          if (status_i.word_done) begin
            nom = status_i.word_fmt ? PH_FMTSZ : PH_SKSZ1;
          end
        end
        PH_ID2: begin
          if (status_i.word_done) begin
            nom = status_i.word_data ? PH_DATASZ : PH_SKSZ2;
          end
        end
        PH_SKSZ1: begin
          if (status_i.word_done) begin
            nom = status_i.word_zero ? PH_ID1 : PH_SKIP1;
          end
        end
        PH_SKSZ2: begin
          if (status_i.word_done) begin
            nom = status_i.word_zero ? PH_ID2 : PH_SKIP2;
          end
        end
        PH_SKIP1: begin
          if (status_i.skip_last) begin
            nom = PH_ID1;
          end
        end
        PH_SKIP2, PH_EXTRA: begin
          if (status_i.skip_last) begin
            nom = PH_ID2;
          end
        end
        PH_FMTSZ: begin
          if (status_i.word_done) begin
            nom = PH_FMT;
          end
        end
        PH_FMT: begin
          if (status_i.fmt_last) begin
            if (!status_i.format_ok) begin
              err_hit  = 1'b1;
              err_code = ERR_FORMAT;
            end else begin
              case (status_i.fmt_size)
                FSZ_BASE:          nom = PH_ID2;
                FSZ_MID, FSZ_LONG: nom = PH_EXTRA;
                default: begin
                  err_hit  = 1'b1;
                  err_code = ERR_FMT_SIZE;
                end
              endcase
            end
          end
        end
        PH_DATASZ: begin
          if (status_i.word_done) begin
            if (status_i.frame_zero) begin
              err_hit  = 1'b1;
              err_code = ERR_ZERO_FRAME;
            end else begin
              nom = status_i.word_zero ? PH_IDLE : PH_DIV;
            end
          end
        end
        PH_DATA: begin
          if (status_i.data_last) begin
            nom = PH_IDLE;
          end
        end
        PH_IDLE: ;
        default: nom = PH_IDLE;
      endcase
      // stream ended early
      if (!err_hit && in_final_i && nom != PH_IDLE) begin
        err_hit  = 1'b1;
        err_code = ERR_TRUNC;
      end
    end
    phase_d = err_hit ? PH_IDLE : nom;
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    if (err_hit) begin
      cmd_o.emit     = EMIT_ERR;
      cmd_o.err_code = err_code;
    end else if (phase_q == PH_DIV) begin
      if (status_i.div_done) begin
        cmd_o.emit          = EMIT_INFO;
        cmd_o.info_from_div = 1'b1;
      end
    end else if (fire) begin
      case (phase_q)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID1, PH_ID2: begin
          cmd_o.take_byte = 1'b1;
        end
        PH_SKSZ1, PH_SKSZ2: begin
          cmd_o.take_byte = 1'b1;
          cmd_o.load_skip = status_i.word_done;
        end
        PH_SKIP1, PH_SKIP2, PH_EXTRA: begin
          cmd_o.dec_skip = 1'b1;
        end
        PH_FMTSZ: begin
          cmd_o.take_byte     = 1'b1;
          cmd_o.load_fmt_size = status_i.word_done;
        end
        PH_FMT: begin
          cmd_o.fmt_byte   = 1'b1;
          cmd_o.load_extra = status_i.fmt_last;
        end
        PH_DATASZ: begin
          cmd_o.take_byte = 1'b1;
          if (status_i.word_done) begin
            if (status_i.word_zero) begin
              cmd_o.emit = EMIT_INFO;
              cmd_o.last = 1'b1;
            end else begin
              cmd_o.start_div = 1'b1;
            end
          end
        end
        PH_DATA: begin
          cmd_o.dec_data = 1'b1;
          cmd_o.emit     = EMIT_DATA;
          cmd_o.last     = status_i.data_last;
        end
        default: ;
      endcase
    end
  end

endmodule

[design/wav_riff_header_parser.sv]
// WAV RIFF header parser, top level. Depends on wrhp_pkg, wrhp_if, wrhp_ctrl, wrhp_dp
// and the assertion macros in wav_riff_header_parser_macros.svh.
//
// Takes a WAV file one byte per transaction on in_i (little-endian fields), checks
// the RIFF/WAVE words, finds the fmt chunk and then the data chunk, and gives on
// out_o one info result, then every data byte with the final one marked. An error
// gives one error result and the block ignores all further bytes until reset. Each
// byte is accepted when offered while the output register is empty or being accepted; a
// result that waits on a stalled output holds the input off until it is taken.
// The info result of a non-empty data chunk is the exception: the frame count comes
// from a bit-serial divider, so after the last byte of the data size the input is
// held off while the divider runs, until the info result appears.
`timescale 1ns / 1ps
`include "wav_riff_header_parser_macros.svh"

module wav_riff_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  wrhp_in_if.sink     in_i,
  wrhp_out_if.source  out_o
);
  import wrhp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  out_item_t  out_item;
  logic       out_valid;
  logic       in_fire;

  wrhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_final_i (in_i.final_byte),
    .in_ready_o (in_i.ready),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  wrhp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_i.stream_byte),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .status_o    (st),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign out_o.valid           = out_valid;
  assign out_o.kind            = out_item.kind;
  assign out_o.sample_byte     = out_item.sample_byte;
  assign out_o.last            = out_item.last;
  assign out_o.format_code     = out_item.format_code;
  assign out_o.channel_count   = out_item.channel_count;
  assign out_o.sample_rate     = out_item.sample_rate;
  assign out_o.bits_per_sample = out_item.bits_per_sample;
  assign out_o.frame_count     = out_item.frame_count;
  assign out_o.data_length     = out_item.data_length;
  assign out_o.error_code      = out_item.error_code;

  assign in_fire = in_i.valid && in_i.ready;

  `WRHP_ASSERT(a_no_accept_in_div, st.div_busy |-> !in_i.ready, "byte taken while dividing")
  `WRHP_ASSERT(a_emit_has_cause, cmd.emit != EMIT_NONE |-> in_fire || st.div_done, "stray result")
  `WRHP_ASSERT(a_out_free_at_div_end, st.div_done |-> !out_o.valid, "output busy at divide end")
  `WRHP_ASSERT_NEXT(a_div_starts, cmd.start_div, st.div_busy, "divider did not start")

endmodule

[tb/tb_wav_riff_header_parser.sv]
// Self-checking testbench for wav_riff_header_parser: streams one generated WAV file with
// random bursts and output stalls and checks every result against a built-in parser model.
// Depends on wrhp_pkg, the wrhp_in_if / wrhp_out_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_wav_riff_header_parser;
  import wrhp_pkg::*;

  localparam logic [31:0] FACT_ID = 32'h7463_6166;

  typedef enum {
    SC_CLEAN,
    SC_EMPTY_DATA,
    SC_BAD_RIFF,
    SC_BAD_WAVE,
    SC_BAD_TAG,
    SC_BAD_FMT_SIZE,
    SC_ZERO_FRAME,
    SC_TRUNC_HEADER,
    SC_TRUNC_DATA
  } file_shape_e;

  typedef struct {
    logic [7:0] val;
    logic       fin;
    logic       drain;
  } wav_byte_t;

  logic clk;
  logic rst_n;

  wrhp_in_if  in_if ();
  wrhp_out_if out_if ();

  wav_riff_header_parser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  wav_byte_t wav_bytes[$];
  out_item_t pending_results[$];
  wav_byte_t head_byte;

  int bytes_offered = 0;
  int bytes_taken   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int burst_left    = 8;
  int gap_left      = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int ready_mode    = 0;
  int mode_left     = 0;

  // parser model state
  phase_e      p_phase    = PH_RIFF;
  logic [2:0]  p_pos      = '0;
  logic [31:0] p_word     = '0;
  logic [31:0] p_skip     = '0;
  logic [31:0] p_fmt_size = '0;
  logic [15:0] p_tag      = '0;
  logic [15:0] p_chans    = '0;
  logic [31:0] p_rate     = '0;
  logic [15:0] p_bits     = '0;
  logic [31:0] p_left     = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // little-endian word assembly shared by the 4-byte ids and sizes outside the fmt body
  function automatic logic gather_word(input logic [7:0] b, output logic [31:0] w);
    w = '0;
    p_word = p_word | ({24'd0, b} << (8 * p_pos[1:0]));
    if (p_pos[1:0] == 2'd3) begin
      w = p_word;
      p_word = '0;
      p_pos = '0;
      return 1'b1;
    end
    p_pos = {1'b0, p_pos[1:0] + 2'd1};
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin, output logic got,
                            output out_item_t r);
    logic [31:0] w;
    logic [3:0]  pos;
    logic [31:0] frame;
    logic [2:0]  err;
    r = '0;
    got = 1'b0;
    err = ERR_NONE;
    w = '0;
    pos = '0;
    frame = '0;
    case (p_phase)
      PH_RIFF: begin
        if (gather_word(b, w)) begin
          if (w != MAGIC_RIFF) err = ERR_MAGIC;
          else p_phase = PH_RSIZE;
        end
      end
      PH_RSIZE: begin
        if (gather_word(b, w)) p_phase = PH_WAVE;
      end
      PH_WAVE: begin
        if (gather_word(b, w)) begin
          if (w != MAGIC_WAVE) err = ERR_MAGIC;
          else p_phase = PH_ID1;
        end
      end
      PH_ID1: begin
        if (gather_word(b, w)) p_phase = (w == MAGIC_FMT) ? PH_FMTSZ : PH_SKSZ1;
      end
      PH_ID2: begin
        if (gather_word(b, w)) p_phase = (w == MAGIC_DATA) ? PH_DATASZ : PH_SKSZ2;
      end
      PH_SKSZ1, PH_SKSZ2: begin
        if (gather_word(b, w)) begin
          p_skip = w;
          if (p_phase == PH_SKSZ1) p_phase = (w == 0) ? PH_ID1 : PH_SKIP1;
          else p_phase = (w == 0) ? PH_ID2 : PH_SKIP2;
        end
      end
      PH_SKIP1, PH_SKIP2, PH_EXTRA: begin
        p_skip = p_skip - 32'd1;
        if (p_skip == 0) p_phase = (p_phase == PH_SKIP1) ? PH_ID1 : PH_ID2;
      end
      PH_FMTSZ: begin
        if (gather_word(b, w)) begin
          p_fmt_size = w;
          p_skip = '0;
          p_tag = '0;
          p_chans = '0;
          p_rate = '0;
          p_bits = '0;
          p_phase = PH_FMT;
        end
      end
      PH_FMT: begin
        pos = p_skip[3:0];
        if (pos < 2) p_tag[8 * pos[0] +: 8] = b;
        else if (pos < 4) p_chans[8 * pos[0] +: 8] = b;
        else if (pos < 8) p_rate[8 * pos[1:0] +: 8] = b;
        else if (pos >= 14) p_bits[8 * pos[0] +: 8] = b;
        p_skip = {28'd0, pos} + 32'd1;
        if (pos == 4'd15) begin
          p_skip = '0;
          if (p_tag != TAG_PCM && p_tag != TAG_FLOAT && p_tag != TAG_EXT) begin
            err = ERR_FORMAT;
          end else if (p_fmt_size == FMT_BASE) begin
            p_phase = PH_ID2;
          end else if (p_fmt_size == FMT_MID || p_fmt_size == FMT_LONG) begin
            p_skip = p_fmt_size - FMT_BASE;
            p_phase = PH_EXTRA;
          end else begin
            err = ERR_FMT_SIZE;
          end
        end
      end
      PH_DATASZ: begin
        if (gather_word(b, w)) begin
          frame = ({16'd0, p_chans} * {16'd0, p_bits}) / 32'd8;
          if (frame == 0) begin
            err = ERR_ZERO_FRAME;
          end else if (fin && w != 0) begin
            err = ERR_TRUNC;
          end else begin
            got = 1'b1;
            r.kind = KIND_INFO;
            r.last = (w == 0);
            r.format_code = p_tag;
            r.channel_count = p_chans;
            r.sample_rate = p_rate;
            r.bits_per_sample = p_bits;
            r.frame_count = w / frame;
            r.data_length = w;
            p_left = w;
            p_phase = (w == 0) ? PH_IDLE : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        p_left = p_left - 32'd1;
        if (fin && p_left != 0) begin
          err = ERR_TRUNC;
        end else begin
          got = 1'b1;
          r.kind = KIND_DATA;
          r.sample_byte = b;
          r.last = (p_left == 0);
          if (p_left == 0) p_phase = PH_IDLE;
        end
      end
      default: p_phase = PH_IDLE;
    endcase
    if (err == ERR_NONE && !got && fin && p_phase != PH_IDLE) err = ERR_TRUNC;
    if (err != ERR_NONE) begin
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = err;
      p_phase = PH_IDLE;
      got = 1'b1;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endfunction

  task automatic push_byte(input logic [7:0] v);
    wav_bytes.push_back('{val: v, fin: 1'b0, drain: 1'b0});
  endtask

  task automatic push_half(input logic [15:0] v);
    push_byte(v[7:0]);
    push_byte(v[15:8]);
  endtask

  task automatic push_word(input logic [31:0] v);
    for (int k = 0; k < 4; k++) push_byte(v[8 * k +: 8]);
  endtask

  // unknown chunk; its id never matches the one the parser is looking for
  task automatic push_chunk(input logic [31:0] banned, input bit empty);
    logic [31:0] id;
    int sz;
    id = $urandom;
    if (id == banned) id = ~id;
    sz = (empty || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    push_word(id);
    push_word(sz);
    repeat (sz) push_byte(8'($urandom));
  endtask

  // byte source
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && bytes_taken != bytes_offered) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (wav_bytes.size() == 0 ||
                 (wav_bytes[0].drain && pending_results.size() != 0)) begin
      in_if.valid <= 1'b0;
    end else begin
      head_byte = wav_bytes.pop_front();
      in_if.valid <= 1'b1;
      in_if.stream_byte <= head_byte.val;
      in_if.final_byte <= head_byte.fin;
      bytes_offered++;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // result sink: long hold-off once the first result waits, then changing stall patterns
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && out_if.valid) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (mode_left % 5 != 0);
      endcase
    end
  end

  // transaction monitor: predict on input, compare on output
  always @(posedge clk) begin
    logic      produced;
    out_item_t result;
    out_item_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d error_code %0d",
                 out_if.kind, out_if.error_code);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_if.kind));
          check_field("sample_byte", 32'(want.sample_byte), 32'(out_if.sample_byte));
          check_field("last", 32'(want.last), 32'(out_if.last));
          check_field("format_code", 32'(want.format_code), 32'(out_if.format_code));
          check_field("channel_count", 32'(want.channel_count), 32'(out_if.channel_count));
          check_field("sample_rate", want.sample_rate, out_if.sample_rate);
          check_field("bits_per_sample", 32'(want.bits_per_sample),
                      32'(out_if.bits_per_sample));
          check_field("frame_count", want.frame_count, out_if.frame_count);
          check_field("data_length", want.data_length, out_if.data_length);
          check_field("error_code", 32'(want.error_code), 32'(out_if.error_code));
        end
      end
      if (in_if.valid && in_if.ready) begin
        bytes_taken++;
        parse_byte(in_if.stream_byte, in_if.final_byte, produced, result);
        if (produced) pending_results.push_back(result);
      end
    end
  end

  initial begin
    file_shape_e shape;
    int          roll;
    int          n_chunks;
    int          hdr_end;
    int          data_start;
    int          n_data;
    int          cut;
    int          noise_start;
    logic [31:0] fsize;
    logic [31:0] len_word;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [15:0] bits;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.stream_byte = '0;
    in_if.final_byte = 1'b0;
    out_if.ready = 1'b0;

    // one reset per run, so one file: its shape is drawn at random
    roll = $urandom_range(0, 99);
    if (roll < 55) shape = SC_CLEAN;
    else if (roll < 60) shape = SC_EMPTY_DATA;
    else if (roll < 64) shape = SC_BAD_RIFF;
    else if (roll < 68) shape = SC_BAD_WAVE;
    else if (roll < 74) shape = SC_BAD_TAG;
    else if (roll < 80) shape = SC_BAD_FMT_SIZE;
    else if (roll < 86) shape = SC_ZERO_FRAME;
    else if (roll < 92) shape = SC_TRUNC_HEADER;
    else shape = SC_TRUNC_DATA;

    push_word((shape == SC_BAD_RIFF) ? (MAGIC_RIFF ^ (32'd1 << $urandom_range(0, 31)))
                                     : MAGIC_RIFF);
    push_word($urandom);
    push_word((shape == SC_BAD_WAVE) ? (MAGIC_WAVE ^ (32'd1 << $urandom_range(0, 31)))
                                     : MAGIC_WAVE);
    n_chunks = $urandom_range(0, 3);
    for (int i = 0; i < n_chunks; i++) push_chunk(MAGIC_FMT, i == 0);

    push_word(MAGIC_FMT);
    if (shape == SC_BAD_FMT_SIZE) begin
      fsize = $urandom_range(0, 64);
      if (fsize == FMT_BASE || fsize == FMT_MID || fsize == FMT_LONG) fsize = fsize + 1;
    end else begin
      roll = $urandom_range(0, 2);
      fsize = (roll == 0) ? FMT_BASE : (roll == 1) ? FMT_MID : FMT_LONG;
    end
    push_word(fsize);
    if (shape == SC_BAD_TAG) begin
      tag = 16'($urandom);
      if (tag == TAG_PCM || tag == TAG_FLOAT || tag == TAG_EXT) tag = 16'h0002;
    end else begin
      roll = $urandom_range(0, 2);
      tag = (roll == 0) ? TAG_PCM : (roll == 1) ? TAG_FLOAT : TAG_EXT;
    end
    if (shape == SC_ZERO_FRAME) begin
      if ($urandom_range(0, 1) == 0) begin
        chans = '0;
        bits = 16'($urandom);
      end else begin
        chans = 16'd1;
        bits = 16'($urandom_range(0, 7));
      end
    end else if ($urandom_range(0, 3) == 0) begin
      chans = 16'($urandom_range(1, 65535));
      bits = 16'($urandom_range(8, 65535));
    end else begin
      chans = 16'($urandom_range(1, 8));
      bits = 16'(8 * $urandom_range(1, 4));
    end
    push_half(tag);
    push_half(chans);
    push_word($urandom);
    push_word($urandom);
    push_half(16'($urandom));
    push_half(bits);
    if (fsize > FMT_BASE && fsize <= 64) repeat (fsize - FMT_BASE) push_byte(8'($urandom));

    push_word(FACT_ID);
    push_word(32'd4);
    push_word($urandom);
    n_chunks = $urandom_range(1, 3);
    for (int i = 0; i < n_chunks; i++) push_chunk(MAGIC_DATA, i == 0);

    push_word(MAGIC_DATA);
    n_data = 0;
    case (shape)
      SC_CLEAN: len_word = $urandom_range(600, 850);
      SC_EMPTY_DATA: len_word = '0;
      SC_TRUNC_DATA: begin
        len_word = $urandom | 32'h0001_0000;
        n_data = $urandom_range(100, 400);
      end
      default: len_word = $urandom_range(1, 64);
    endcase
    if (shape != SC_TRUNC_DATA) n_data = len_word;
    push_word(len_word);
    hdr_end = wav_bytes.size();
    if (shape == SC_EMPTY_DATA) wav_bytes[hdr_end - 1].fin = 1'($urandom_range(0, 1));
    if (shape == SC_TRUNC_HEADER) begin
      cut = $urandom_range(0, hdr_end - 1);
      wav_bytes[cut].fin = 1'b1;
      while (wav_bytes.size() > cut + 1) void'(wav_bytes.pop_back());
      n_data = 0;
    end

    data_start = wav_bytes.size();
    for (int i = 0; i < n_data; i++) begin
      if (i == 0) push_byte(8'h00);
      else if (i == 1) push_byte(8'hFF);
      else push_byte(8'($urandom));
    end
    if (n_data > 0) begin
      if (shape == SC_TRUNC_DATA) wav_bytes[wav_bytes.size() - 1].fin = 1'b1;
      else if (shape == SC_CLEAN) wav_bytes[wav_bytes.size() - 1].fin = 1'($urandom_range(0, 1));
    end
    if (n_data > 2) wav_bytes[data_start + n_data / 2].drain = 1'b1;

    // trailing bytes after the file must be ignored; short files are padded out
    noise_start = wav_bytes.size();
    while (wav_bytes.size() < noise_start + 24 || wav_bytes.size() < 900) begin
      push_byte(8'($urandom));
      wav_bytes[wav_bytes.size() - 1].fin = 1'($urandom_range(0, 1));
    end
    wav_bytes[noise_start + 12].drain = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (wav_bytes.size() != 0 || bytes_taken != bytes_offered ||
           pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[wav_riff_header_parser.f]
+incdir+design
design/wrhp_pkg.sv
design/wrhp_if.sv
design/wrhp_div.sv
design/wrhp_dp.sv
design/wrhp_ctrl.sv
design/wav_riff_header_parser.sv
tb/tb_wav_riff_header_parser.sv
